>>> rtl/uvs_pkg.sv
// shared types, constants and sine table math for the uv sphere quad vertex block
package uvs_pkg;

  localparam int INDEX_BITS_DEF = 10;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int PHASE_W      = 16;
  localparam int QUARTER_BITS = 14;
  localparam int SINE_W       = 15;
  localparam int COORD_W      = 17;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int LANES        = 4;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLAR_STEP    = 2'd2;

  localparam logic [CFG_W-1:0] RADIUS_RST       = 16'd256;
  localparam logic [CFG_W-1:0] AZIMUTH_STEP_RST = 16'd16384;
  localparam logic [CFG_W-1:0] POLAR_STEP_RST   = 16'd16384;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  localparam int SEQ_W = 3;
  localparam logic [SEQ_W-1:0] SEQ_A0 = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_B  = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_C0 = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_A1 = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_C1 = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_D  = 3'd5;

  // rom lanes
  localparam int LANE_SB = 0;
  localparam int LANE_CB = 1;
  localparam int LANE_SA = 2;
  localparam int LANE_CA = 3;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic       valid;
    logic [1:0] corner;
    logic       last;
  } vtx_tag_t;

  // q30 taylor series of sin(x), rounded to unsigned q0.15 (full scale 32767)
  function automatic logic [SINE_W-1:0] sine_from_x(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum * 64'd32767 + 64'd536870912) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

>>> rtl/uvs_req_if.sv
// quad request channel
interface uvs_req_if #(
  parameter int INDEX_BITS = uvs_pkg::INDEX_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] stack_index;
  logic [INDEX_BITS-1:0] slice_index;

  modport source (output valid, output stack_index, output slice_index, input ready);
  modport sink   (input valid, input stack_index, input slice_index, output ready);
endinterface

>>> rtl/uvs_vtx_if.sv
// vertex result channel
interface uvs_vtx_if;
  logic                                valid;
  logic                                ready;
  logic signed [uvs_pkg::COORD_W-1:0]  coord_x;
  logic signed [uvs_pkg::COORD_W-1:0]  coord_y;
  logic signed [uvs_pkg::COORD_W-1:0]  coord_z;
  logic [1:0]                          corner_id;
  logic                                last_vertex;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output corner_id, output last_vertex, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input corner_id, input last_vertex, output ready);
endinterface

>>> rtl/uv_sphere_quad_vertices_top.sv
// top level of the uv sphere quad vertex generator
// Each quad request (stack index, slice index) yields six vertices, A B C A C D, one per
// clock on the result channel when it is not stalled, and a new request is taken in the
// cycle its last corner is issued. The rate is set by the quad sequencer, which registers
// one corner per cycle unless stalled and hands it to a six-stage pipeline (phase
// multiply, table addressing, sine table read, radius products, cross products,
// rounding). A stall on the result channel holds the whole pipeline. The configuration
// registers are to be written by the user through the cfg port only while no
// transaction is in flight; the block itself does not enforce it.
module uv_sphere_quad_vertices_top #(
  parameter int INDEX_BITS       = uvs_pkg::INDEX_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  uvs_req_if.sink                           in_chan,
  uvs_vtx_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]         cfg_data
);

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

  logic [uvs_pkg::CFG_W-1:0] radius_r;
  logic [uvs_pkg::CFG_W-1:0] azimuth_step_r;
  logic [uvs_pkg::CFG_W-1:0] polar_step_r;

  logic                                   adv;
  uvs_pkg::vtx_tag_t                      tag0;
  logic [INDEX_BITS:0]                    p0;
  logic [INDEX_BITS:0]                    q0;
  uvs_pkg::vtx_tag_t                      tag2;
  logic [uvs_pkg::LANES-1:0][ADDR_W-1:0]  addr2;
  logic [uvs_pkg::LANES-1:0]              neg2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= uvs_pkg::RADIUS_RST;
      azimuth_step_r <= uvs_pkg::AZIMUTH_STEP_RST;
      polar_step_r   <= uvs_pkg::POLAR_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::CFG_RADIUS:       radius_r       <= cfg_data;
        uvs_pkg::CFG_AZIMUTH_STEP: azimuth_step_r <= cfg_data;
        uvs_pkg::CFG_POLAR_STEP:   polar_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves unless the output register holds a stalled transaction
  assign adv = !out_chan.valid || out_chan.ready;

  uvs_seq #(
    .INDEX_BITS (INDEX_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_stack_index (in_chan.stack_index),
    .in_slice_index (in_chan.slice_index),
    .tag_o          (tag0),
    .p_o            (p0),
    .q_o            (q0)
  );

  uvs_phase #(
    .INDEX_BITS       (INDEX_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .tag_i        (tag0),
    .p_i          (p0),
    .q_i          (q0),
    .azimuth_step (azimuth_step_r),
    .polar_step   (polar_step_r),
    .tag_o        (tag2),
    .addr_o       (addr2),
    .neg_o        (neg2)
  );

  uvs_vertex #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_vertex (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .tag_i           (tag2),
    .addr_i          (addr2),
    .neg_i           (neg2),
    .radius          (radius_r),
    .out_valid       (out_chan.valid),
    .out_coord_x     (out_chan.coord_x),
    .out_coord_y     (out_chan.coord_y),
    .out_coord_z     (out_chan.coord_z),
    .out_corner_id   (out_chan.corner_id),
    .out_last_vertex (out_chan.last_vertex)
  );

endmodule

>>> rtl/uvs_seq.sv
// quad sequencer: holds one request and issues its six corner indices
module uvs_seq #(
  parameter int INDEX_BITS = uvs_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [INDEX_BITS-1:0]  in_stack_index,
  input  logic [INDEX_BITS-1:0]  in_slice_index,
  output uvs_pkg::vtx_tag_t      tag_o,
  output logic [INDEX_BITS:0]    p_o,
  output logic [INDEX_BITS:0]    q_o
);

  logic                          busy_r;
  logic [uvs_pkg::SEQ_W-1:0]     cnt_r;
  logic [INDEX_BITS-1:0]         i_r;
  logic [INDEX_BITS-1:0]         j_r;
  uvs_pkg::vtx_tag_t             tag_r;
  logic [INDEX_BITS:0]           p_r;
  logic [INDEX_BITS:0]           q_r;

  logic       dp;
  logic       dq;
  logic [1:0] corner;
  logic       last;
  logic       last_emit;
  logic       accept;

  always_comb begin
    unique case (cnt_r)
      uvs_pkg::SEQ_A0: begin dp = 1'b0; dq = 1'b0; corner = uvs_pkg::CORNER_A; last = 1'b0; end
      uvs_pkg::SEQ_B:  begin dp = 1'b0; dq = 1'b1; corner = uvs_pkg::CORNER_B; last = 1'b0; end
      uvs_pkg::SEQ_C0: begin dp = 1'b1; dq = 1'b1; corner = uvs_pkg::CORNER_C; last = 1'b0; end
      uvs_pkg::SEQ_A1: begin dp = 1'b0; dq = 1'b0; corner = uvs_pkg::CORNER_A; last = 1'b0; end
      uvs_pkg::SEQ_C1: begin dp = 1'b1; dq = 1'b1; corner = uvs_pkg::CORNER_C; last = 1'b0; end
      uvs_pkg::SEQ_D:  begin dp = 1'b1; dq = 1'b0; corner = uvs_pkg::CORNER_D; last = 1'b1; end
      default:         begin dp = 1'b0; dq = 1'b0; corner = uvs_pkg::CORNER_A; last = 1'b0; end
    endcase
  end

  assign last_emit = (cnt_r == uvs_pkg::SEQ_D);
  assign in_ready  = !busy_r || (last_emit && adv);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= uvs_pkg::SEQ_A0;
      tag_r  <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= uvs_pkg::SEQ_A0;
      end else if (busy_r && adv) begin
        if (last_emit) begin
          busy_r <= 1'b0;
          cnt_r  <= uvs_pkg::SEQ_A0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (adv) begin
        tag_r.valid  <= busy_r;
        tag_r.corner <= corner;
        tag_r.last   <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_r <= in_stack_index;
      j_r <= in_slice_index;
    end
    if (adv) begin
      p_r <= {1'b0, i_r} + (INDEX_BITS + 1)'(dp);
      q_r <= {1'b0, j_r} + (INDEX_BITS + 1)'(dq);
    end
  end

  assign tag_o = tag_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

>>> rtl/uvs_phase.sv
// phase multiply and quarter-wave table addressing
module uvs_phase #(
  parameter int INDEX_BITS       = uvs_pkg::INDEX_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_DEPTH_DEF,
  localparam int ADDR_W          = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        adv,
  input  uvs_pkg::vtx_tag_t                           tag_i,
  input  logic [INDEX_BITS:0]                         p_i,
  input  logic [INDEX_BITS:0]                         q_i,
  input  logic [uvs_pkg::CFG_W-1:0]                   azimuth_step,
  input  logic [uvs_pkg::CFG_W-1:0]                   polar_step,
  output uvs_pkg::vtx_tag_t                           tag_o,
  output logic [uvs_pkg::LANES-1:0][ADDR_W-1:0]       addr_o,
  output logic [uvs_pkg::LANES-1:0]                   neg_o
);

  localparam int KPROD_W = uvs_pkg::QUARTER_BITS + ADDR_W;

  typedef struct packed {
    logic              neg;
    logic [ADDR_W-1:0] idx;
  } rom_addr_t;

  function automatic rom_addr_t quarter_addr(input logic [uvs_pkg::PHASE_W-1:0] ph);
    logic [KPROD_W-1:0] prod;
    logic [ADDR_W-1:0]  k;
    rom_addr_t          a;
    prod  = KPROD_W'(ph[uvs_pkg::QUARTER_BITS-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);
    k     = prod[uvs_pkg::QUARTER_BITS +: ADDR_W];
    a.idx = ph[uvs_pkg::QUARTER_BITS] ? ADDR_W'(SINE_TABLE_DEPTH) - k : k;
    a.neg = ph[uvs_pkg::QUARTER_BITS + 1];
    return a;
  endfunction

  logic [INDEX_BITS+uvs_pkg::PHASE_W:0]     pol_prod;
  logic [INDEX_BITS+uvs_pkg::PHASE_W:0]     azi_prod;
  uvs_pkg::vtx_tag_t                        tag1_r;
  logic [uvs_pkg::PHASE_W-1:0]              pol1_r;
  logic [uvs_pkg::PHASE_W-1:0]              azi1_r;
  uvs_pkg::vtx_tag_t                        tag2_r;
  logic [uvs_pkg::LANES-1:0][ADDR_W-1:0]    addr2_r;
  logic [uvs_pkg::LANES-1:0]                neg2_r;
  rom_addr_t [uvs_pkg::LANES-1:0]           lane_addr;

  assign pol_prod = p_i * polar_step;
  assign azi_prod = q_i * azimuth_step;

  always_comb begin
    lane_addr[uvs_pkg::LANE_SB] = quarter_addr(pol1_r);
    lane_addr[uvs_pkg::LANE_CB] = quarter_addr(pol1_r + uvs_pkg::QUARTER_TURN);
    lane_addr[uvs_pkg::LANE_SA] = quarter_addr(azi1_r);
    lane_addr[uvs_pkg::LANE_CA] = quarter_addr(azi1_r + uvs_pkg::QUARTER_TURN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else if (adv) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pol1_r <= pol_prod[uvs_pkg::PHASE_W-1:0];
      azi1_r <= azi_prod[uvs_pkg::PHASE_W-1:0];
      for (int l = 0; l < uvs_pkg::LANES; l++) begin
        addr2_r[l] <= lane_addr[l].idx;
        neg2_r[l]  <= lane_addr[l].neg;
      end
    end
  end

  assign tag_o  = tag2_r;
  assign addr_o = addr2_r;
  assign neg_o  = neg2_r;

endmodule

>>> rtl/uvs_sine_rom.sv
// quarter-wave sine table with registered read
module uvs_sine_rom #(
  parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_DEPTH_DEF,
  localparam int ADDR_W          = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ADDR_W-1:0]           addr,
  output logic [uvs_pkg::SINE_W-1:0]  data_o
);

  logic [uvs_pkg::SINE_W-1:0] rom_c [SINE_TABLE_DEPTH+1];
  logic [uvs_pkg::SINE_W-1:0] data_r;

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic [63:0] XQ30 =
      (64'(k) * uvs_pkg::PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [uvs_pkg::SINE_W-1:0] ENTRY = uvs_pkg::sine_from_x(XQ30);
    assign rom_c[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom_c[addr];
    end
  end

  assign data_o = data_r;

endmodule

>>> rtl/uvs_vertex.sv
// table read, sign fix, radius and cross products, rounding and output register
module uvs_vertex #(
  parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_DEPTH_DEF,
  localparam int ADDR_W          = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        adv,
  input  uvs_pkg::vtx_tag_t                           tag_i,
  input  logic [uvs_pkg::LANES-1:0][ADDR_W-1:0]       addr_i,
  input  logic [uvs_pkg::LANES-1:0]                   neg_i,
  input  logic [uvs_pkg::CFG_W-1:0]                   radius,
  output logic                                        out_valid,
  output logic signed [uvs_pkg::COORD_W-1:0]          out_coord_x,
  output logic signed [uvs_pkg::COORD_W-1:0]          out_coord_y,
  output logic signed [uvs_pkg::COORD_W-1:0]          out_coord_z,
  output logic [1:0]                                  out_corner_id,
  output logic                                        out_last_vertex
);

  localparam int SGN_W  = uvs_pkg::SINE_W + 1;
  localparam int RP_W   = 32;
  localparam int XP_W   = 48;

  function automatic logic [uvs_pkg::COORD_W-1:0] round30(input logic [XP_W-1:0] p);
    logic [XP_W-1:0] s;
    s = p + 48'h0000_2000_0000 - XP_W'(p[XP_W-1]);
    return s[30 +: uvs_pkg::COORD_W];
  endfunction

  function automatic logic [uvs_pkg::COORD_W-1:0] round15(input logic [RP_W-1:0] p);
    logic [RP_W-1:0] s;
    s = p + 32'h0000_4000 - RP_W'(p[RP_W-1]);
    return s[15 +: uvs_pkg::COORD_W];
  endfunction

  logic [uvs_pkg::LANES-1:0][uvs_pkg::SINE_W-1:0] mag3;
  logic signed [SGN_W-1:0]   sgn [uvs_pkg::LANES];
  uvs_pkg::vtx_tag_t         tag3_r;
  logic [uvs_pkg::LANES-1:0] neg3_r;

  logic signed [uvs_pkg::CFG_W:0] rad_s;
  logic signed [RP_W-1:0]    sbr_prod;
  logic signed [RP_W-1:0]    y_prod;
  uvs_pkg::vtx_tag_t         tag4_r;
  logic signed [RP_W-1:0]    sbr4_r;
  logic signed [RP_W-1:0]    y4_r;
  logic signed [SGN_W-1:0]   sa4_r;
  logic signed [SGN_W-1:0]   ca4_r;

  logic signed [XP_W-1:0]    x_prod;
  logic signed [XP_W-1:0]    z_prod;
  uvs_pkg::vtx_tag_t         tag5_r;
  logic signed [XP_W-1:0]    x5_r;
  logic signed [XP_W-1:0]    z5_r;
  logic signed [RP_W-1:0]    y5_r;

  logic                                     out_valid_r;
  logic signed [uvs_pkg::COORD_W-1:0]       coord_x_r;
  logic signed [uvs_pkg::COORD_W-1:0]       coord_y_r;
  logic signed [uvs_pkg::COORD_W-1:0]       coord_z_r;
  logic [1:0]                               corner_r;
  logic                                     last_r;

  for (genvar l = 0; l < uvs_pkg::LANES; l++) begin : g_lane
    uvs_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
      .clk    (clk),
      .en     (adv),
      .addr   (addr_i[l]),
      .data_o (mag3[l])
    );
    assign sgn[l] = neg3_r[l] ? -$signed({1'b0, mag3[l]}) : $signed({1'b0, mag3[l]});
  end

  assign rad_s    = $signed({1'b0, radius});
  assign sbr_prod = rad_s * sgn[uvs_pkg::LANE_SB];
  assign y_prod   = rad_s * sgn[uvs_pkg::LANE_CB];
  assign x_prod   = sbr4_r * sa4_r;
  assign z_prod   = sbr4_r * ca4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r      <= '0;
      tag4_r      <= '0;
      tag5_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag3_r      <= tag_i;
      tag4_r      <= tag3_r;
      tag5_r      <= tag4_r;
      out_valid_r <= tag5_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg3_r    <= neg_i;
      sbr4_r    <= sbr_prod;
      y4_r      <= y_prod;
      sa4_r     <= sgn[uvs_pkg::LANE_SA];
      ca4_r     <= sgn[uvs_pkg::LANE_CA];
      x5_r      <= x_prod;
      z5_r      <= z_prod;
      y5_r      <= y4_r;
      coord_x_r <= round30(x5_r);
      coord_y_r <= round15(y5_r);
      coord_z_r <= round30(z5_r);
      corner_r  <= tag5_r.corner;
      last_r    <= tag5_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coord_x     = coord_x_r;
  assign out_coord_y     = coord_y_r;
  assign out_coord_z     = coord_z_r;
  assign out_corner_id   = corner_r;
  assign out_last_vertex = last_r;

endmodule

>>> rtl/uvs_checker.sv
// port-level checker for the uv sphere quad vertex block and its bind
module uvs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [uvs_pkg::COORD_W-1:0] out_coord_x,
  input logic signed [uvs_pkg::COORD_W-1:0] out_coord_y,
  input logic signed [uvs_pkg::COORD_W-1:0] out_coord_z,
  input logic [1:0]                         out_corner_id,
  input logic                               out_last_vertex
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coord_x) &&
      $stable(out_coord_y) && $stable(out_coord_z) && $stable(out_corner_id) &&
      $stable(out_last_vertex))
    else $error("result transaction changed while stalled");

  a_last_is_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_vertex |-> out_corner_id == uvs_pkg::CORNER_D)
    else $error("last vertex is not corner d");

  a_d_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_corner_id == uvs_pkg::CORNER_D |-> out_last_vertex)
    else $error("corner d without last flag");

  // a valid vertex right after a completed last vertex opens the next quad with corner a
  a_quad_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_vertex |=>
      !out_valid || out_corner_id == uvs_pkg::CORNER_A)
    else $error("quad does not start with corner a");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind uv_sphere_quad_vertices_top uvs_checker u_uvs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_coord_x     (out_chan.coord_x),
  .out_coord_y     (out_chan.coord_y),
  .out_coord_z     (out_chan.coord_z),
  .out_corner_id   (out_chan.corner_id),
  .out_last_vertex (out_chan.last_vertex)
);
